FILE: sv/assert_macros.svh
// Assertion macros for the line-to-frame block.
// Needs clk and rst in the scope of each use; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define LCF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset
`define LCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: sv/lcf_pkg.sv
// Shared types, constants and digit decoders for the line-to-frame block.
// No dependencies.
package lcf_pkg;

  // Default sizing
  localparam int LINE_DEPTH_DEF     = 50;
  localparam int MAX_ID_DIGITS_DEF  = 8;
  localparam int MAX_DATA_BYTES_DEF = 8;

  // Field widths
  localparam int ID_W   = 27;
  localparam int LEN_W  = 4;
  localparam int PAY_W  = 64;
  localparam int DIG_W  = 5;

  // Characters
  localparam logic [7:0] CHAR_NUL  = 8'h00;
  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_LA   = 8'h61;
  localparam logic [7:0] CHAR_LF   = 8'h66;

  // Digit value that marks a character as not a digit
  localparam logic [DIG_W-1:0] BAD_DIGIT = 5'd16;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_WALK = 3'b010,
    ST_HOLD = 3'b100
  } lcf_state_t;

  typedef struct packed {
    logic [ID_W-1:0]  frame_id;
    logic [LEN_W-1:0] data_len;
    logic             remote_request;
    logic [PAY_W-1:0] payload;
    logic             format_error;
  } lcf_frame_t;

  // Decimal digit value, BAD_DIGIT otherwise
  function automatic logic [DIG_W-1:0] dec_val(input logic [7:0] c);
    logic [7:0] d;
    d = c - CHAR_ZERO;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      return d[DIG_W-1:0];
    end
    return BAD_DIGIT;
  endfunction

  // Lowercase hex digit value, BAD_DIGIT otherwise
  function automatic logic [DIG_W-1:0] hex_val(input logic [7:0] c);
    logic [7:0] d;
    logic [7:0] x;
    d = c - CHAR_ZERO;
    x = c - CHAR_LA + 8'd10;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      return d[DIG_W-1:0];
    end
    if (c >= CHAR_LA && c <= CHAR_LF) begin
      return x[DIG_W-1:0];
    end
    return BAD_DIGIT;
  endfunction

endpackage

FILE: sv/lcf_line_mem.sv
// Line buffer: single-port-write, single-port-read synchronous memory.
// Depends on nothing; read data is registered.
module lcf_line_mem #(
  parameter int LINE_DEPTH = lcf_pkg::LINE_DEPTH_DEF,
  localparam int IDX_W = $clog2(LINE_DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [7:0]       wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [7:0]       rd_data
);

  logic [7:0] mem [LINE_DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: sv/lcf_parse.sv
// Line parser: walks the line buffer one position per cycle and builds a frame.
// Depends on lcf_pkg; reads through the registered port of lcf_line_mem.
module lcf_parse #(
  parameter int LINE_DEPTH     = lcf_pkg::LINE_DEPTH_DEF,
  parameter int MAX_ID_DIGITS  = lcf_pkg::MAX_ID_DIGITS_DEF,
  parameter int MAX_DATA_BYTES = lcf_pkg::MAX_DATA_BYTES_DEF,
  localparam int IDX_W = $clog2(LINE_DEPTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [IDX_W-1:0]   start_fill,
  output logic [IDX_W-1:0]   rd_addr,
  input  logic [7:0]         rd_data,
  output logic               busy,
  output logic               out_valid,
  input  logic               out_stall,
  output lcf_pkg::lcf_frame_t frame
);

  lcf_pkg::lcf_state_t state;

  logic [IDX_W-1:0]             rd_ptr;
  logic [IDX_W-1:0]             fill;
  logic                         dvalid;
  logic [IDX_W-1:0]             dpos;
  logic                         dok;
  logic [lcf_pkg::ID_W-1:0]     id_acc;
  logic [lcf_pkg::LEN_W-1:0]    a_cnt;
  logic [lcf_pkg::LEN_W-1:0]    len;
  logic                         flag;
  logic [lcf_pkg::PAY_W-1:0]    pay;
  logic                         err;

  logic [7:0]                   c;
  logic [lcf_pkg::DIG_W-1:0]    dv;
  logic [lcf_pkg::DIG_W-1:0]    hv;
  logic [IDX_W-1:0]             a_ext;
  logic [IDX_W-1:0]             k;
  logic [5:0]                   nib_bit;
  logic                         last_nib;
  logic [lcf_pkg::ID_W-1:0]     id_next;
  logic                         load;

  assign rd_addr = rd_ptr;
  assign busy    = (state != lcf_pkg::ST_IDLE);

  // Frame moves into the output register when that register is free or drains
  assign load = (state == lcf_pkg::ST_HOLD) && (!out_valid || !out_stall);

  // Decode of the byte returned by the memory; unwritten positions read as zero
  always_comb begin
    c        = dok ? rd_data : lcf_pkg::CHAR_NUL;
    dv       = lcf_pkg::dec_val(c);
    hv       = lcf_pkg::hex_val(c);
    a_ext    = IDX_W'(a_cnt);
    k        = dpos - a_ext - IDX_W'(4);
    nib_bit  = {k[3:1], ~k[0], 2'b00};
    last_nib = ({1'b0, k[3:0]} == ({len, 1'b0} - 5'd1));
    id_next  = (id_acc << 3) + (id_acc << 1) + lcf_pkg::ID_W'(dv[3:0]);
  end

  // Walk sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lcf_pkg::ST_IDLE;
      dvalid    <= 1'b0;
    end else begin
      case (state)
        lcf_pkg::ST_IDLE: begin
          if (start) begin
            state  <= lcf_pkg::ST_WALK;
            rd_ptr <= IDX_W'(1);
            fill   <= start_fill;
            dvalid <= 1'b0;
            id_acc <= '0;
            a_cnt  <= '0;
            len    <= '0;
            flag   <= 1'b0;
            pay    <= '0;
            err    <= 1'b0;
          end
        end
        lcf_pkg::ST_WALK: begin
          rd_ptr <= rd_ptr + IDX_W'(1);
          dvalid <= 1'b1;
          dpos   <= rd_ptr;
          dok    <= (rd_ptr < fill);
          if (dvalid) begin
            if (dpos == IDX_W'(1)) begin
              // identifier digit count
              if (dv == '0 || dv > lcf_pkg::DIG_W'(MAX_ID_DIGITS)) begin
                err   <= 1'b1;
                state <= lcf_pkg::ST_HOLD;
              end else begin
                a_cnt <= dv[3:0];
              end
            end else if (dpos <= a_ext + IDX_W'(1)) begin
              // identifier digits, most significant first
              if (dv > lcf_pkg::DIG_W'(9)) begin
                err   <= 1'b1;
                state <= lcf_pkg::ST_HOLD;
              end else begin
                id_acc <= id_next;
              end
            end else if (dpos == a_ext + IDX_W'(2)) begin
              // data length
              if (dv > lcf_pkg::DIG_W'(MAX_DATA_BYTES)) begin
                err   <= 1'b1;
                state <= lcf_pkg::ST_HOLD;
              end else begin
                len <= dv[3:0];
              end
            end else if (dpos == a_ext + IDX_W'(3)) begin
              // remote flag
              if (dv > lcf_pkg::DIG_W'(9)) begin
                err   <= 1'b1;
                state <= lcf_pkg::ST_HOLD;
              end else begin
                flag <= (dv != '0);
                if (len == '0) begin
                  state <= lcf_pkg::ST_HOLD;
                end
              end
            end else begin
              // hex nibbles, high nibble of each byte first
              if (hv == lcf_pkg::BAD_DIGIT) begin
                err   <= 1'b1;
                state <= lcf_pkg::ST_HOLD;
              end else begin
                pay[nib_bit +: 4] <= hv[3:0];
                if (last_nib) begin
                  state <= lcf_pkg::ST_HOLD;
                end
              end
            end
          end
        end
        lcf_pkg::ST_HOLD: begin
          // wait for the output register
          if (load) begin
            state <= lcf_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= lcf_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid            <= 1'b1;
      frame.frame_id       <= err ? '0 : id_acc;
      frame.data_len       <= err ? '0 : len;
      frame.remote_request <= err ? 1'b0 : flag;
      frame.payload        <= err ? '0 : pay;
      frame.format_error   <= err;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

FILE: sv/ascii_line_to_can_frame.sv
// Top level: serial text line to CAN frame description.
// Depends on lcf_pkg, lcf_line_mem, lcf_parse and assert_macros.svh.
//
//   channel | handshake           | beat
//   --------+---------------------+----------------------------------------------
//   in      | in_valid / in_stall | rx_byte
//   out     | out_valid/out_stall | frame_id, data_len, remote_request, payload,
//           |                     | format_error
//
// Each accepted byte but NUL is written into the line memory; a NUL is dropped.
// A carriage return starts a walk over the line memory, one read per cycle through its
// single registered read port; in_stall then stays high while the parser is busy, until
// its frame is loaded into the output register, and the walk stops early at a bad field.
// Reset clears the write index and the parser control; positions at or beyond the fill
// count read as zero, so there is no clearing pass. A stalled output holds the next
// frame back in the parser and keeps in_stall high until the previous frame is taken.
`include "assert_macros.svh"
module ascii_line_to_can_frame #(
  parameter int LINE_DEPTH     = lcf_pkg::LINE_DEPTH_DEF,
  parameter int MAX_ID_DIGITS  = lcf_pkg::MAX_ID_DIGITS_DEF,
  parameter int MAX_DATA_BYTES = lcf_pkg::MAX_DATA_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [7:0]                 rx_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [lcf_pkg::ID_W-1:0]   frame_id,
  output logic [lcf_pkg::LEN_W-1:0]  data_len,
  output logic                       remote_request,
  output logic [lcf_pkg::PAY_W-1:0]  payload,
  output logic                       format_error
);

  localparam int IDX_W = $clog2(LINE_DEPTH);

  logic [IDX_W-1:0]    write_index;
  logic [IDX_W-1:0]    write_index_next;
  logic [IDX_W-1:0]    wi_inc;
  logic                in_accept;
  logic                store_en;
  logic                is_cr;
  logic                busy;
  logic [IDX_W-1:0]    rd_addr;
  logic [7:0]          rd_data;
  lcf_pkg::lcf_frame_t frame;
  logic                err_clean;
  logic                len_ok;
  logic                index_ok;

  assign in_stall  = busy;
  assign in_accept = in_valid && !in_stall;
  assign is_cr     = (rx_byte == lcf_pkg::CHAR_CR);
  assign store_en  = in_accept && (rx_byte != lcf_pkg::CHAR_NUL);
  assign wi_inc    = write_index + IDX_W'(1);

  // Write index: cleared after a carriage return or when the line fills up
  always_comb begin
    write_index_next = write_index;
    if (store_en) begin
      if (is_cr || wi_inc == IDX_W'(LINE_DEPTH - 1)) begin
        write_index_next = '0;
      end else begin
        write_index_next = wi_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_index <= '0;
    end else begin
      write_index <= write_index_next;
    end
  end

  lcf_line_mem #(
    .LINE_DEPTH(LINE_DEPTH)
  ) u_mem (
    .clk     (clk),
    .wr_en   (store_en),
    .wr_addr (write_index),
    .wr_data (rx_byte),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  lcf_parse #(
    .LINE_DEPTH    (LINE_DEPTH),
    .MAX_ID_DIGITS (MAX_ID_DIGITS),
    .MAX_DATA_BYTES(MAX_DATA_BYTES)
  ) u_parse (
    .clk        (clk),
    .rst        (rst),
    .start      (in_accept && is_cr),
    .start_fill (wi_inc),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .frame      (frame)
  );

  assign frame_id       = frame.frame_id;
  assign data_len       = frame.data_len;
  assign remote_request = frame.remote_request;
  assign payload        = frame.payload;
  assign format_error   = frame.format_error;

  // Checks
  assign err_clean = frame_id == '0 && data_len == '0 && !remote_request && payload == '0;
  assign len_ok    = data_len <= lcf_pkg::LEN_W'(MAX_DATA_BYTES);
  assign index_ok  = write_index <= IDX_W'(LINE_DEPTH - 2);

  `LCF_ASSERT_NOW(a_err_fields_zero, out_valid && format_error, err_clean, "error frame not clean")
  `LCF_ASSERT_NOW(a_len_range, out_valid && !format_error, len_ok, "data length out of range")
  `LCF_ASSERT_NEXT(a_cr_starts_walk, in_accept && is_cr, in_stall, "walk not started")
  `LCF_ASSERT_NOW(a_index_bound, 1'b1, index_ok, "write index past line end")

endmodule

FILE: dv/tb_ascii_line_to_can_frame.sv
// Self-checking testbench for ascii_line_to_can_frame: feeds text lines byte by byte
// and checks every emitted frame against an in-bench line parser or a frame typed in the table.
// Depends on lcf_pkg and the RTL of the block only.
module tb_ascii_line_to_can_frame;
  timeunit 1ns;
  timeprecision 1ps;
  import lcf_pkg::*;

  localparam int        LONG_HOLD    = 400;
  localparam int        ITEM_TARGET  = 1400;
  localparam int        DRAIN_LIMIT  = 20000;
  localparam logic [7:0] PAD_CHAR    = 8'h7A;
  localparam logic [7:0] UPPER_A     = 8'h41;
  localparam string     HEX_CHARS    = "0123456789abcdef";

  // Frames whose value is obvious from the line
  localparam lcf_frame_t NO_FRAME  = '0;
  localparam lcf_frame_t ZERO_OK   = '0;
  localparam lcf_frame_t ERR_FRAME = '{frame_id: '0, data_len: '0, remote_request: 1'b0,
                                       payload: '0, format_error: 1'b1};
  localparam lcf_frame_t TOP_FRAME = '{frame_id: 27'd99999999, data_len: 4'd8,
                                       remote_request: 1'b1,
                                       payload: 64'hFFFF_FFFF_FFFF_FFFF, format_error: 1'b0};

  typedef struct {
    string      text;
    int         nul_at;  // insert a NUL before this position, -1 for none
    int         pad;     // filler bytes appended after the text
    bit         add_cr;
    bit         typed;   // use frame below instead of the parser
    lcf_frame_t frame;
  } line_row_t;

  typedef struct {
    bit         typed;
    lcf_frame_t frame;
  } cr_note_t;

  // Directed lines; a carriage return is appended where add_cr is set
  line_row_t dir_rows [20] = '{
    '{"x1000",                              -1,  0, 1'b1, 1'b1, ZERO_OK},
    '{"x89999999981ffffffffffffffff",       -1,  0, 1'b1, 1'b1, TOP_FRAME},
    '{"x800000000800123456789abcdef",       -1,  0, 1'b1, 1'b0, NO_FRAME},
    '{"",                                   -1,  0, 1'b1, 1'b1, ERR_FRAME},
    '{"x0",                                 -1,  0, 1'b1, 1'b1, ERR_FRAME},
    '{"x9123456789000",                     -1,  0, 1'b1, 1'b1, ERR_FRAME},
    '{"x11",                                -1,  0, 1'b1, 1'b1, ERR_FRAME},
    '{"x2a500",                             -1,  0, 1'b1, 1'b1, ERR_FRAME},
    '{"x2:000",                             -1,  0, 1'b1, 1'b1, ERR_FRAME},
    '{"x1590",                              -1,  0, 1'b1, 1'b1, ERR_FRAME},
    '{"x150x",                              -1,  0, 1'b1, 1'b1, ERR_FRAME},
    '{"x1510AB",                            -1,  0, 1'b1, 1'b1, ERR_FRAME},
    '{"x1510g0",                            -1,  0, 1'b1, 1'b1, ERR_FRAME},
    '{"x1519a5",                            -1,  0, 1'b1, 1'b0, NO_FRAME},
    '{"x1520a5",                            -1,  0, 1'b1, 1'b1, ERR_FRAME},
    '{"x1510ff",                             3,  0, 1'b1, 1'b0, NO_FRAME},
    '{"\3771000",                           -1,  0, 1'b1, 1'b1, ZERO_OK},
    '{"x1510ff",                            -1, 41, 1'b1, 1'b0, NO_FRAME},
    '{"",                                   -1, 49, 1'b0, 1'b0, NO_FRAME},
    '{"x312305",                            -1,  0, 1'b1, 1'b0, NO_FRAME}
  };

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        rx_byte = 8'h00;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [ID_W-1:0]   frame_id;
  logic [LEN_W-1:0]  data_len;
  logic              remote_request;
  logic [PAY_W-1:0]  payload;
  logic              format_error;

  // Parser state mirrored in the bench
  logic [7:0]        line_buf [LINE_DEPTH_DEF];
  int unsigned       line_fill;

  lcf_frame_t        frames_due [$];
  cr_note_t          cr_notes [$];
  int                errors = 0;
  int                sent_count = 0;
  bit                tx_calm = 1'b0;
  bit                rx_calm = 1'b0;
  bit                hold_req = 1'b0;

  lcf_frame_t        got_frame;
  lcf_frame_t        want_frame;
  lcf_frame_t        pred_frame;
  bit                pred_emits;
  cr_note_t          cr_note;

  ascii_line_to_can_frame u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .rx_byte        (rx_byte),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .frame_id       (frame_id),
    .data_len       (data_len),
    .remote_request (remote_request),
    .payload        (payload),
    .format_error   (format_error)
  );

  always #5 clk = ~clk;

  // Hard stop
  initial begin
    #(5_000_000);
    $display("tb_ascii_line_to_can_frame: done, errors");
    $finish;
  end

  function automatic void clear_line_buf();
    foreach (line_buf[i]) line_buf[i] = 8'h00;
    line_fill = 0;
  endfunction

  function automatic logic [7:0] held_char(int unsigned pos);
    return (pos < LINE_DEPTH_DEF) ? line_buf[pos] : 8'h00;
  endfunction

  // 16 flags a non-digit
  function automatic int unsigned dec_digit(logic [7:0] c);
    if (c >= CHAR_ZERO && c <= CHAR_NINE) return 32'(c - CHAR_ZERO);
    return 16;
  endfunction

  // Lowercase only; 16 flags a non-digit
  function automatic int unsigned hex_nibble(logic [7:0] c);
    if (c >= CHAR_LA && c <= CHAR_LF) return 32'(c - CHAR_LA) + 10;
    return dec_digit(c);
  endfunction

  // Parse the held line into a frame
  function automatic lcf_frame_t decode_line();
    int unsigned ndig, dlen, rflag, digit, hi, lo, pos, i;
    int unsigned id_acc;
    logic [63:0] data;
    bit          bad;
    lcf_frame_t  fr;
    fr = '0;
    bad = 1'b0;
    id_acc = 0;
    data = '0;
    ndig = dec_digit(held_char(1));
    if (ndig < 1 || ndig > MAX_ID_DIGITS_DEF) begin
      bad = 1'b1;
    end else begin
      for (i = 0; i < ndig; i++) begin
        digit = dec_digit(held_char(2 + i));
        if (digit > 9) begin
          bad = 1'b1;
          digit = 0;
        end
        id_acc = id_acc * 10 + digit;
      end
      dlen = dec_digit(held_char(ndig + 2));
      rflag = dec_digit(held_char(ndig + 3));
      if (dlen > MAX_DATA_BYTES_DEF || rflag > 9) begin
        bad = 1'b1;
      end else begin
        pos = ndig + 4;
        for (i = 0; i < dlen && !bad; i++) begin
          hi = hex_nibble(held_char(pos));
          lo = hex_nibble(held_char(pos + 1));
          if (hi > 15 || lo > 15) begin
            bad = 1'b1;
          end else begin
            data[8*i +: 8] = {hi[3:0], lo[3:0]};
          end
          pos += 2;
        end
      end
    end
    if (bad) begin
      fr.format_error = 1'b1;
    end else begin
      fr.frame_id       = id_acc[ID_W-1:0];
      fr.data_len       = dlen[LEN_W-1:0];
      fr.remote_request = (rflag != 0);
      fr.payload        = data;
    end
    return fr;
  endfunction

  // Advance the line buffer by one byte; a carriage return yields a frame
  function automatic void predict_char(input logic [7:0] c, output bit emits,
                                       output lcf_frame_t fr);
    emits = 1'b0;
    fr = '0;
    if (c != CHAR_NUL) begin
      if (line_fill < LINE_DEPTH_DEF) line_buf[line_fill] = c;
      line_fill = (line_fill + 1) & 6'h3F;
    end
    if (c == CHAR_CR) begin
      fr = decode_line();
      emits = 1'b1;
      clear_line_buf();
    end
    if (line_fill >= LINE_DEPTH_DEF - 1) clear_line_buf();
  endfunction

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      errors++;
    end
  endtask

  // Output beats are checked first, then the input beat of the same edge is predicted
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        got_frame = '{frame_id, data_len, remote_request, payload, format_error};
        if (frames_due.size() == 0) begin
          $display("%0t: unexpected frame, expected none, got 0x%0h", $time, got_frame);
          errors++;
        end else begin
          want_frame = frames_due.pop_front();
          check_field("frame_id", 64'(want_frame.frame_id), 64'(got_frame.frame_id));
          check_field("data_len", 64'(want_frame.data_len), 64'(got_frame.data_len));
          check_field("remote_request", 64'(want_frame.remote_request),
                      64'(got_frame.remote_request));
          check_field("payload", want_frame.payload, got_frame.payload);
          check_field("format_error", 64'(want_frame.format_error),
                      64'(got_frame.format_error));
        end
      end
      if (in_valid && !in_stall) begin
        predict_char(rx_byte, pred_emits, pred_frame);
        if (rx_byte == CHAR_CR && cr_notes.size() != 0) begin
          cr_note = cr_notes.pop_front();
          if (cr_note.typed) pred_frame = cr_note.frame;
        end
        if (pred_emits) frames_due.push_back(pred_frame);
      end
    end
  end

  // Offer one byte and hold it until the block takes it
  task automatic send_char(input logic [7:0] c, input bit typed, input lcf_frame_t fr);
    int       gap;
    cr_note_t note;
    gap = tx_calm ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    if (c == CHAR_CR) begin
      note.typed = typed;
      note.frame = fr;
      cr_notes.push_back(note);
    end
    in_valid <= 1'b1;
    rx_byte  <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  // Frame receiver: random stalls, calm stretches, one long hold-off on request
  initial begin : rx_side
    int hold;
    wait (rst == 1'b0);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        for (hold = 0; hold < LONG_HOLD; hold++) @(posedge clk);
        hold_req = 1'b0;
      end
      if ($urandom_range(0, 7) == 0) rx_calm = !rx_calm;
      hold = rx_calm ? 0 : $urandom_range(0, 6);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Reset, directed lines, random lines, drain
  initial begin : tx_side
    logic [7:0]  ln [$];
    int          k, ndig, nlen, kind, pos, drain;
    bit          hold_done;
    bit          end_cr;
    clear_line_buf();
    hold_done = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table
    foreach (dir_rows[row]) begin
      for (k = 0; k < dir_rows[row].text.len(); k++) begin
        if (k == dir_rows[row].nul_at) send_char(CHAR_NUL, 1'b0, NO_FRAME);
        send_char(dir_rows[row].text[k], 1'b0, NO_FRAME);
      end
      repeat (dir_rows[row].pad) send_char(PAD_CHAR, 1'b0, NO_FRAME);
      if (dir_rows[row].add_cr) begin
        send_char(CHAR_CR, dir_rows[row].typed, dir_rows[row].frame);
      end
    end

    // Random lines: mostly well formed, some corrupted, some noise
    while (sent_count < ITEM_TARGET) begin
      if ($urandom_range(0, 5) == 0) tx_calm = !tx_calm;
      if (!hold_done && sent_count > ITEM_TARGET / 2) begin
        hold_req = 1'b1;
        hold_done = 1'b1;
      end
      ln.delete();
      do k = $urandom_range(1, 255); while (k == CHAR_CR);
      ln.push_back(8'(k));
      ndig = $urandom_range(1, MAX_ID_DIGITS_DEF);
      ln.push_back(CHAR_ZERO + 8'(ndig));
      repeat (ndig) ln.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
      nlen = $urandom_range(0, MAX_DATA_BYTES_DEF);
      ln.push_back(CHAR_ZERO + 8'(nlen));
      ln.push_back($urandom_range(0, 1) ? CHAR_ZERO : CHAR_ZERO + 8'($urandom_range(0, 9)));
      repeat (2 * nlen) ln.push_back(HEX_CHARS[$urandom_range(0, 15)]);
      end_cr = 1'b1;
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        // one byte replaced by anything
        ln[$urandom_range(0, ln.size() - 1)] = 8'($urandom_range(0, 255));
      end else if (kind < 13) begin
        // digit count out of range
        ln[1] = $urandom_range(0, 1) ? CHAR_ZERO : CHAR_NINE;
      end else if (kind < 17 && nlen > 0) begin
        // uppercase hex digit
        pos = ndig + 4 + $urandom_range(0, 2 * nlen - 1);
        ln[pos] = UPPER_A + 8'($urandom_range(0, 5));
      end else if (kind < 21) begin
        // line cut short
        k = $urandom_range(0, ln.size() - 1);
        while (ln.size() > k) void'(ln.pop_back());
      end else if (kind < 26) begin
        // raw noise, every byte value
        ln.delete();
        repeat ($urandom_range(1, 60)) ln.push_back(8'($urandom_range(0, 255)));
        end_cr = ($urandom_range(0, 1) == 1);
      end else if (kind < 29) begin
        // padded line that may run into the full-buffer clear
        repeat ($urandom_range(25, 45)) ln.push_back(PAD_CHAR);
      end
      if ($urandom_range(0, 9) == 0) ln.insert($urandom_range(0, ln.size()), CHAR_NUL);
      if (end_cr) ln.push_back(CHAR_CR);
      foreach (ln[j]) send_char(ln[j], 1'b0, NO_FRAME);
    end
    in_valid <= 1'b0;

    // Drain outstanding frames
    drain = 0;
    while ((frames_due.size() != 0 || cr_notes.size() != 0) && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (40) @(posedge clk);
    if (frames_due.size() != 0) begin
      $display("%0t: %0d frames never arrived, next expected 0x%0h", $time,
               frames_due.size(), frames_due[0]);
      errors++;
    end
    if (errors == 0) begin
      $display("tb_ascii_line_to_can_frame: done, clean");
    end else begin
      $display("tb_ascii_line_to_can_frame: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+sv
sv/lcf_pkg.sv
sv/lcf_line_mem.sv
sv/lcf_parse.sv
sv/ascii_line_to_can_frame.sv
dv/tb_ascii_line_to_can_frame.sv
